FILE: rtl/core/led_blink_pattern_sequencer_top_macros.svh
// ----------------------------------------------------------------------------
// led_blink_pattern_sequencer_top_macros
// assertion macros for the led blink sequencer checker
// ----------------------------------------------------------------------------
`ifndef LED_BLINK_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define LED_BLINK_PATTERN_SEQUENCER_TOP_MACROS_SVH

// plain property, checked on every rising edge outside reset
`define LBPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// same-cycle implication
`define LBPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// next-cycle implication
`define LBPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

FILE: rtl/core/lbps_pkg.sv
// ----------------------------------------------------------------------------
// lbps_pkg
// types, constants and pattern table of the led blink pattern sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbps_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MS_W    = 12;
  localparam int unsigned PAT_W   = 3;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned DATA_W  = 8;

  localparam logic [TIME_W-1:0] BLIP_MS = TIME_W'(40);

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_SELECT = 2'd1,
    ACT_BLIP   = 2'd2
  } action_e;

  typedef enum logic [PAT_W-1:0] {
    PAT_OFF         = 3'd0,
    PAT_BOOT        = 3'd1,
    PAT_PORTAL      = 3'd2,
    PAT_WIFI        = 3'd3,
    PAT_OTA         = 3'd4,
    PAT_RESET_ARMED = 3'd5
  } pattern_e;

  // mask applied to the incremented step index; zero for patterns without steps
  function automatic logic [IDX_W-1:0] step_mask(input logic [PAT_W-1:0] pat);
    logic [IDX_W-1:0] m;
    case (pat)
      PAT_BOOT, PAT_WIFI, PAT_OTA, PAT_RESET_ARMED: m = IDX_W'(1);
      PAT_PORTAL:                                    m = IDX_W'(3);
      default:                                       m = '0;
    endcase
    return m;
  endfunction

  function automatic logic has_steps(input logic [PAT_W-1:0] pat);
    return (pat == PAT_BOOT) || (pat == PAT_PORTAL) || (pat == PAT_WIFI) ||
           (pat == PAT_OTA) || (pat == PAT_RESET_ARMED);
  endfunction

  // duration of one step in ms
  function automatic logic [MS_W-1:0] step_ms(input logic [PAT_W-1:0] pat,
                                              input logic [IDX_W-1:0] idx);
    logic [MS_W-1:0] ms;
    case (pat)
      PAT_BOOT:        ms = MS_W'(100);
      PAT_PORTAL: begin
        case (idx)
          2'd0:    ms = MS_W'(120);
          2'd1:    ms = MS_W'(160);
          2'd2:    ms = MS_W'(120);
          default: ms = MS_W'(1600);
        endcase
      end
      PAT_WIFI:        ms = idx[0] ? MS_W'(2940) : MS_W'(60);
      PAT_OTA:         ms = MS_W'(70);
      PAT_RESET_ARMED: ms = MS_W'(40);
      default:         ms = '0;
    endcase
    return ms;
  endfunction

  // every stepped pattern lights on even steps and goes dark on odd ones
  function automatic logic step_lit(input logic [IDX_W-1:0] idx);
    return ~idx[0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/led_blink_pattern_sequencer_top.sv
// ----------------------------------------------------------------------------
// led_blink_pattern_sequencer_top
// status led driver stepping through looped blink patterns
// ----------------------------------------------------------------------------
// channel | direction | signals                         | payload
// s_axis  | in        | tvalid tready tdata tuser       | pattern_select, action
// m_axis  | out       | tvalid tready tdata             | led_lit, pin_level
// cfg     | in        | cfg_valid cfg_ready cfg_data    | active_low
//
// one transaction is taken per cycle unless the buffer is full; its result is
// computed in the same cycle from the state registers into a two-entry output buffer
// s_axis_tready_o drops only when both buffer entries hold untaken results,
// so a stalled output side costs no input cycles until the buffer is full
// reset clears all timing state, the pattern (off), the led and the polarity
// cfg_ready_o is always high; writes are expected only while idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module led_blink_pattern_sequencer_top
  import lbps_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input stream
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [DATA_W-1:0] s_axis_tdata_i,  // [2:0] pattern_select, rest zero
  input  wire logic [ACT_W-1:0]  s_axis_tuser_i,  // [1:0] action
  // result stream
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [DATA_W-1:0]      m_axis_tdata_o,  // [0] led_lit, [1] pin_level, rest zero
  // configuration write
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_data_i       // active_low
);

  // --------------------------------------------------------------------------
  // state registers
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0] time_q, time_d;
  logic [TIME_W-1:0] step_dl_q, step_dl_d;
  logic [TIME_W-1:0] blip_dl_q, blip_dl_d;
  logic [PAT_W-1:0]  pat_q, pat_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              led_q, led_d;
  logic              active_low_q;

  // output buffer: slot 0 is the head
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] slot0_q, slot0_d;
  logic [1:0] slot1_q, slot1_d;

  logic              in_accept;
  logic              out_pop;
  logic [PAT_W-1:0]  sel;
  action_e           act;

  logic [TIME_W-1:0] time_inc;
  logic [TIME_W-1:0] blip_diff;
  logic [TIME_W-1:0] step_diff;
  logic              blip_on;
  logic              step_due;
  logic [IDX_W-1:0]  idx_nxt;
  logic [1:0]        result;

  assign sel       = s_axis_tdata_i[PAT_W-1:0];
  assign act       = action_e'(s_axis_tuser_i);
  assign in_accept = s_axis_tvalid_i & s_axis_tready_o;
  assign out_pop   = m_axis_tvalid_o & m_axis_tready_i;

  // --------------------------------------------------------------------------
  // timing compares, all modulo 2^32
  // --------------------------------------------------------------------------
  assign time_inc  = time_q + TIME_W'(1);
  assign blip_diff = blip_dl_q - time_inc;
  // blip still ahead: strictly positive as a signed value
  assign blip_on   = (blip_diff != '0) & ~blip_diff[TIME_W-1];
  assign step_diff = time_inc - step_dl_q;
  // deadline reached or passed
  assign step_due  = ~step_diff[TIME_W-1];
  assign idx_nxt   = (idx_q + IDX_W'(1)) & step_mask(pat_q);

  // --------------------------------------------------------------------------
  // transaction decode and next state
  // --------------------------------------------------------------------------
  always_comb begin
    time_d    = time_q;
    step_dl_d = step_dl_q;
    blip_dl_d = blip_dl_q;
    pat_d     = pat_q;
    idx_d     = idx_q;
    led_d     = led_q;
    if (in_accept) begin
      unique case (act)
        ACT_TICK: begin
          time_d = time_inc;
          if (blip_on) begin
            // blip holds the led on and freezes the pattern
            led_d = 1'b1;
          end else if (!has_steps(pat_q)) begin
            led_d = 1'b0;
          end else if (step_due) begin
            idx_d     = idx_nxt;
            step_dl_d = time_inc + TIME_W'(step_ms(pat_q, idx_nxt));
            led_d     = step_lit(idx_nxt);
          end
        end
        ACT_SELECT: begin
          // reselecting the running pattern leaves it undisturbed
          if (sel != pat_q) begin
            pat_d = sel;
            idx_d = '0;
            if (has_steps(sel)) begin
              led_d     = step_lit('0);
              step_dl_d = time_q + TIME_W'(step_ms(sel, '0));
            end else begin
              led_d = 1'b0;
            end
          end
        end
        ACT_BLIP: begin
          blip_dl_d = time_q + BLIP_MS;
        end
        default: begin
          // unused action code: state untouched, level still reported
        end
      endcase
    end
  end

  assign result = {led_d ^ active_low_q, led_d};

  // --------------------------------------------------------------------------
  // two-entry output buffer
  // --------------------------------------------------------------------------
  always_comb begin
    cnt_d   = cnt_q + {1'b0, in_accept} - {1'b0, out_pop};
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (out_pop && (cnt_q == 2'd2)) begin
      slot0_d = slot1_q;
    end
    if (in_accept) begin
      if ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_pop)) begin
        slot0_d = result;
      end else begin
        slot1_d = result;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q       <= '0;
      step_dl_q    <= '0;
      blip_dl_q    <= '0;
      pat_q        <= PAT_OFF;
      idx_q        <= '0;
      led_q        <= 1'b0;
      active_low_q <= 1'b0;
      cnt_q        <= '0;
    end else begin
      time_q    <= time_d;
      step_dl_q <= step_dl_d;
      blip_dl_q <= blip_dl_d;
      pat_q     <= pat_d;
      idx_q     <= idx_d;
      led_q     <= led_d;
      cnt_q     <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        active_low_q <= cfg_data_i;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = {{(DATA_W-2){1'b0}}, slot0_q};
  assign cfg_ready_o     = 1'b1;

endmodule

`default_nettype wire

FILE: rtl/core/lbps_checker.sv
// ----------------------------------------------------------------------------
// lbps_checker
// port-level checks of the led blink pattern sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "led_blink_pattern_sequencer_top_macros.svh"

module lbps_checker
  import lbps_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid_i,
  input wire logic              s_axis_tready_o,
  input wire logic              m_axis_tvalid_o,
  input wire logic              m_axis_tready_i,
  input wire logic [DATA_W-1:0] m_axis_tdata_o,
  input wire logic              cfg_valid_i,
  input wire logic              cfg_ready_o,
  input wire logic              cfg_data_i
);

  // mirror of the polarity register as seen on the configuration port
  logic pol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pol_q <= cfg_data_i;
    end
  end

  `LBPS_ASSERT_NXT(a_accept_gives_result, clk_i, rst_ni,
                   s_axis_tvalid_i && s_axis_tready_o, m_axis_tvalid_o)
  `LBPS_ASSERT_IMP(a_full_means_valid, clk_i, rst_ni, !s_axis_tready_o, m_axis_tvalid_o)
  `LBPS_ASSERT_IMP(a_pin_polarity, clk_i, rst_ni, m_axis_tvalid_o,
                   m_axis_tdata_o[1] == (m_axis_tdata_o[0] ^ pol_q))
  `LBPS_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o))

endmodule

bind led_blink_pattern_sequencer_top lbps_checker u_lbps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o),
  .cfg_data_i      (cfg_data_i)
);

`default_nettype wire
